>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, muted during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/tsrp_pkg.sv
package tsrp_pkg;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_SERVICE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_EMITTED  = 3'd1,
      ST_STALE    = 3'd2,
      ST_MISSING  = 3'd3,
      ST_HELD     = 3'd4,
      ST_CLEARED  = 3'd5,
      ST_FULL     = 3'd6
   } status_type;

   localparam logic [6:0] PRESSURE_RESET = 7'd90;
   localparam int unsigned PERCENT_SCALE = 100;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] start_offset;
      logic [31:0] run_length;
      logic [31:0] payload;
      logic [6:0]  downstream_fill;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_offset;
      logic [31:0] out_length;
      logic [31:0] out_payload;
      logic [31:0] missing_key;
      logic [6:0]  usage_percent;
   } rsp_type;

   // Classified command passed from front to back.
   typedef struct packed {
      op_type      op;
      logic        go;       // service step allowed by pressure
      logic [31:0] key;
      logic [31:0] len;
      logic [31:0] data;
   } cmd_type;

endpackage

>>> hdl/tsrp_front.sv
module tsrp_front
   import tsrp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [6:0] csr_data,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_data
);
   // Two-entry queue toward the back end.
   logic [6:0] limit_ff, limit_in;
   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   cmd_type    cmd_new;
   logic       push, pop;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid) ? csr_data : limit_ff;

   always_comb begin
      cmd_new.op   = op_type'(req_data.opcode);
      cmd_new.go   = (req_data.downstream_fill < limit_ff);
      cmd_new.key  = req_data.start_offset;
      cmd_new.len  = req_data.run_length;
      cmd_new.data = req_data.payload;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rd_ff];
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign wr_in     = wr_ff ^ push;
   assign rd_in     = rd_ff ^ pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= PRESSURE_RESET;
         cnt_ff   <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         cnt_ff   <= cnt_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
      if (push) begin
         q_ff[wr_ff] <= cmd_new;
      end
   end

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3, "queue count overflow")
   `ASSERT_NEXT(a_full_stall, clock, reset, cnt_ff == 2'd2 && !pop, !req_ready, "full queue took beat")
endmodule

>>> hdl/tsrp_back.sv
module tsrp_back
   import tsrp_pkg::*;
#(
   parameter int unsigned SLOTS = 128
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int PW = CW + 7;
   // count*100 < 2^15 and SLOTS < 2^8, so a 23-bit reciprocal floors exactly.
   localparam int RSH = 23;
   localparam int SW  = PW + RSH;
   localparam logic [RSH-1:0] RECIP =
      RSH'(((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_READ  = 6'b000100,
      S_DEC   = 6'b001000,
      S_PCT   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   // Key, length and data live in one memory; busy bits are flops.
   logic [95:0]      mem [SLOTS];
   logic [SLOTS-1:0] busy_ff, busy_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [31:0]      exp_ff, exp_in;
   state_type        st_ff, st_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             found_ff, found_in;
   logic [IW-1:0]    best_ff, best_in;
   logic [31:0]      bkey_ff, bkey_in;
   logic [95:0]      rdat_ff;
   logic [IW-1:0]    raddr;
   logic             wen;
   logic [IW-1:0]    waddr;
   logic [95:0]      wdat;
   rsp_type          res_ff, res_in;   // working result, copied out at S_OUT
   rsp_type          rsp_ff, rsp_in;
   logic             rv_ff, rv_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [SW-1:0]    scaled;
   logic [IW-1:0]    scan_idx;
   logic             scan_rd_ff;
   logic [IW-1:0]    scan_slot_ff;

   assign scan_idx = idx_ff[IW-1:0];
   assign cmd_ready = (st_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign scaled    = SW'(prod_ff) * SW'(RECIP);

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdat;
      end
      rdat_ff <= mem[raddr];
   end

   always_comb begin
      st_in    = st_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bkey_in  = bkey_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      exp_in   = exp_ff;
      res_in   = res_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff && !rsp_ready;
      prod_in  = prod_ff;
      raddr    = scan_idx;
      wen      = 1'b0;
      waddr    = '0;
      wdat     = {cmd_ff.key, cmd_ff.len, cmd_ff.data};
      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd_data;
               idx_in   = '0;
               found_in = 1'b0;
               res_in   = '0;
               res_in.status = ST_HELD;
               unique case (cmd_data.op)
                  OP_INSERT: begin
                     st_in = S_SCAN;
                  end
                  OP_SERVICE: begin
                     st_in = (cmd_data.go && count_ff != '0) ? S_SCAN : S_PCT;
                  end
                  OP_CLEAR: begin
                     busy_in  = '0;
                     count_in = '0;
                     exp_in   = '0;
                     res_in.status = ST_CLEARED;
                     st_in    = S_PCT;
                  end
                  default: st_in = S_PCT;
               endcase
            end
         end
         S_SCAN: begin
            // One slot a cycle; memory read data arrives in the cycle after its index.
            if (cmd_ff.op == OP_INSERT) begin
               if (!busy_ff[scan_idx]) begin
                  wen      = 1'b1;
                  waddr    = scan_idx;
                  busy_in[scan_idx] = 1'b1;
                  count_in = count_ff + CW'(1);
                  res_in.status = ST_INSERTED;
                  st_in    = S_PCT;
               end else if (idx_ff == CW'(SLOTS - 1)) begin
                  res_in.status = ST_FULL;
                  st_in    = S_PCT;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               if (scan_rd_ff && busy_ff[scan_slot_ff]
                   && (!found_ff || rdat_ff[95:64] < bkey_ff)) begin
                  found_in = 1'b1;
                  best_in  = scan_slot_ff;
                  bkey_in  = rdat_ff[95:64];
               end
               if (idx_ff == CW'(SLOTS)) begin
                  st_in = S_READ;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         S_READ: begin
            raddr = best_ff;
            st_in = S_DEC;
         end
         S_DEC: begin
            if (bkey_ff == exp_ff || bkey_ff == '0) begin
               res_in.status      = ST_EMITTED;
               res_in.out_offset  = bkey_ff;
               res_in.out_length  = rdat_ff[63:32];
               res_in.out_payload = rdat_ff[31:0];
               exp_in   = bkey_ff + rdat_ff[63:32];
               busy_in[best_ff] = 1'b0;
               count_in = count_ff - CW'(1);
            end else if (bkey_ff < exp_ff) begin
               res_in.status     = ST_STALE;
               res_in.out_offset = bkey_ff;
               busy_in[best_ff] = 1'b0;
               count_in = count_ff - CW'(1);
            end else begin
               res_in.status      = ST_MISSING;
               res_in.missing_key = exp_ff;
            end
            st_in = S_PCT;
         end
         S_PCT: begin
            prod_in = PW'(count_ff) * PW'(PERCENT_SCALE);
            st_in   = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rsp_in = res_ff;
               rsp_in.usage_percent = scaled[RSH+6:RSH];
               rv_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         busy_ff  <= '0;
         count_ff <= '0;
         exp_ff   <= '0;
         rv_ff    <= 1'b0;
         scan_rd_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         busy_ff  <= busy_in;
         count_ff <= count_in;
         exp_ff   <= exp_in;
         rv_ff    <= rv_in;
         scan_rd_ff <= (st_ff == S_SCAN) && (idx_ff < CW'(SLOTS));
      end
      scan_slot_ff <= scan_idx;
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bkey_ff  <= bkey_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      prod_ff  <= prod_in;
   end

   `include "assert_macros.svh"
   `ASSERT_IMPL(a_count, clock, reset, 1'b1, CW'($countones(busy_ff)) == count_ff, "count")
   `ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(st_ff), "state not one-hot")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp_ready, rv_ff && $stable(rsp_ff), "rsp dropped")
endmodule

>>> hdl/timestamp_reorder_pool.sv
// Channel  | Dir | Handshake            | Beat
// req_     | in  | req_valid/req_ready  | req_data  (req_type)
// rsp_     | out | rsp_valid/rsp_ready  | rsp_data  (rsp_type)
// csr_     | in  | csr_valid/csr_ready  | csr_data  (pressure_limit)
// Insert: first-free scan. Service: min-key scan over the slot memory, one read
// per cycle. Clear and held commands skip the scan.
// Synchronous reset clears busy bits, count, expected key; no memory sweep.
// A two-beat queue lets requests land while the back end scans or rsp stalls.
module timestamp_reorder_pool
   import tsrp_pkg::*;
#(
   parameter int unsigned SLOTS = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);
   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   // Front: limit register, pressure compare, command queue.
   tsrp_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_data,
      .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   // Back: slot pool, scan sequencer, result register.
   tsrp_back #(.SLOTS(SLOTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
